// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ----- hw/rtl/aclp_pkg.sv -----
// Types, constants and codes of the AT response line parser.
`timescale 1ns / 1ps
package aclp_pkg;

  localparam int RX_BUF_SIZE  = 64;
  localparam int PREFIX_BYTES = 8;
  localparam int HOOK_SLOTS   = 2;

  localparam int ADDR_W     = $clog2(RX_BUF_SIZE);
  localparam int CNT_W      = $clog2(RX_BUF_SIZE + 1);
  localparam int HEAD_BYTES = (PREFIX_BYTES > 5) ? PREFIX_BYTES : 5;
  localparam int RUN_W      = 6;
  localparam int RUN_MAX    = 63;
  localparam int LEN_W      = 6;
  localparam int ELAPSED_W  = 17;
  localparam int LIMIT_W    = 16;
  localparam int PLEN_W     = 4;
  localparam int HCOUNT_W   = 2;
  localparam int PREFIX_W   = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int JOBQ_DEPTH = 2;
  localparam int JQ_PTR_W   = $clog2(JOBQ_DEPTH);

  // Item kinds
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_ARM  = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_OK      = 3'd0;
  localparam logic [2:0] KIND_ERROR   = 3'd1;
  localparam logic [2:0] KIND_PROMPT  = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT = 3'd3;
  localparam logic [2:0] KIND_LINE    = 3'd4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOOK_COUNT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PFX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PLEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PFX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PLEN  = 3'd4;

  // Characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         rx_byte;
    logic [LIMIT_W-1:0] wait_limit;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       kind;
    logic             hook_index;
    logic [7:0]       line_byte;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } out_item_t;

  // Work handed from the front to the back
  typedef struct packed {
    logic             run;
    logic [2:0]       kind;
    logic             hook;
    logic [LEN_W-1:0] len;
    logic [RUN_W-1:0] count;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } jobq_stat_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_EMIT
  } bk_state_t;

endpackage

// ----- hw/rtl/at_response_line_parser.sv -----
// An ok, error, prompt or timeout word goes through the job queue and the output register
// to the result ports; a captured line is queued at its LF and then read out of the store.
// Throughput: one input word per cycle while results are popped and no line is being sent.
// Each byte of a captured line goes out by a store read, then the output register;
// input is held full after its LF until the last byte has been loaded into the output register.
// Reset: synchronous active-low rst_n clears counters, timer, registers and queues.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module at_response_line_parser import aclp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  jobq_stat_t q_stat;
  job_t       wr_job, rd_job;
  logic       q_push, q_pop;
  rd_req_t    rd_req;
  logic [7:0] rd_data;
  logic       run_done, run_pending;

  aclp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_item     (in_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_job       (wr_job),
    .rd_req      (rd_req),
    .rd_data     (rd_data),
    .run_done    (run_done),
    .run_pending (run_pending)
  );

  aclp_job_q u_job_q (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .wr_job (wr_job),
    .q_pop  (q_pop),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  aclp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .q_job    (rd_job),
    .q_pop    (q_pop),
    .rd_req   (rd_req),
    .rd_data  (rd_data),
    .run_done (run_done),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  // a line being sent must keep the store frozen
  `ASSERT_IMP(a_pending_stalls, clk, rst_n, run_pending, full)
  `ASSERT_IMP(a_push_has_room, clk, rst_n, q_push, !q_stat.full)
  `ASSERT_IMP(a_done_owned, clk, rst_n, run_done, run_pending)
  `ASSERT_NXT(a_done_releases, clk, rst_n, run_done, !run_pending)

endmodule

// ----- hw/rtl/aclp_job_q.sv -----
// Short job queue between the classifying front and the emitting back.
`timescale 1ns / 1ps
module aclp_job_q import aclp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_push,
  input  job_t       wr_job,
  input  logic       q_pop,
  output job_t       rd_job,
  output jobq_stat_t stat
);

  job_t                slot_r [JOBQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [JQ_PTR_W:0]   fill_r;

  function automatic logic [JQ_PTR_W-1:0] ptr_inc(input logic [JQ_PTR_W-1:0] p);
    ptr_inc = (p == JQ_PTR_W'(JOBQ_DEPTH - 1)) ? '0 : p + JQ_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (q_push) begin
      slot_r[wr_ptr_r] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (q_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (q_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (q_push && !q_pop)      fill_r <= fill_r + (JQ_PTR_W+1)'(1);
      else if (!q_push && q_pop) fill_r <= fill_r - (JQ_PTR_W+1)'(1);
    end
  end

  assign rd_job     = slot_r[rd_ptr_r];
  assign stat.full  = (fill_r == (JQ_PTR_W+1)'(JOBQ_DEPTH));
  assign stat.empty = (fill_r == '0);

endmodule

// ----- hw/rtl/aclp_front.sv -----
// Front: takes words, keeps the line store and wait timer, classifies lines into jobs.
`timescale 1ns / 1ps
module aclp_front import aclp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  jobq_stat_t            q_stat,
  output logic                  q_push,
  output job_t                  q_job,
  input  rd_req_t               rd_req,
  output logic [7:0]            rd_data,
  input  logic                  run_done,
  output logic                  run_pending
);

  logic [7:0]           line_mem [RX_BUF_SIZE];
  logic [7:0]           head_r [HEAD_BYTES];
  logic [7:0]           last_r;
  logic [7:0]           rd_data_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 armed_r, armed_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [LIMIT_W-1:0]   limit_r, limit_nxt;
  logic                 run_pending_r, run_pending_nxt;

  logic [HCOUNT_W-1:0]  hook_count_r;
  logic [PREFIX_W-1:0]  first_prefix_r, second_prefix_r;
  logic [PLEN_W-1:0]    first_plen_r, second_plen_r;

  logic                 accept, mem_we, line_end;
  logic                 is_ok, is_err, is_prompt;
  logic [CNT_W-1:0]     len;
  logic [RUN_W-1:0]     run_count;
  logic [HCOUNT_W-1:0]  slots;
  logic [PREFIX_W-1:0]  pfx [2];
  logic [PLEN_W-1:0]    plen [2];
  logic [1:0]           hit;

  assign accept   = push && !full;
  assign full     = q_stat.full || run_pending_r;
  assign len      = cnt_r - CNT_W'(1);
  assign line_end = (in_item.rx_byte == CH_LF) && (cnt_r != '0) && (last_r == CH_CR);

  assign is_ok     = (cnt_r == CNT_W'(3)) && (head_r[0] == CH_O) && (head_r[1] == CH_K);
  assign is_err    = (cnt_r == CNT_W'(6)) && (head_r[0] == CH_E) && (head_r[1] == CH_R) &&
                     (head_r[2] == CH_R) && (head_r[3] == CH_O) && (head_r[4] == CH_R);
  assign is_prompt = (cnt_r == CNT_W'(2)) && (head_r[0] == CH_GT) && (head_r[1] == CH_SPACE);

  assign run_count = (int'(len) > RUN_MAX) ? RUN_W'(RUN_MAX) : RUN_W'(len);
  assign slots     = (hook_count_r > HCOUNT_W'(HOOK_SLOTS)) ? HCOUNT_W'(HOOK_SLOTS)
                                                           : hook_count_r;
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + ELAPSED_W'(1);

  // Prefix matchers compare against the head copy of the line
  always_comb begin
    pfx[0] = first_prefix_r;
    pfx[1] = second_prefix_r;
    for (int h = 0; h < 2; h++) begin
      plen[h] = (h == 0) ? first_plen_r : second_plen_r;
      if (int'(plen[h]) > PREFIX_BYTES) plen[h] = PLEN_W'(PREFIX_BYTES);
      hit[h] = (HCOUNT_W'(h) < slots) && (int'(len) >= int'(plen[h]));
      for (int i = 0; i < PREFIX_BYTES; i++) begin
        if ((i < int'(plen[h])) && (head_r[i] != pfx[h][8*i +: 8])) hit[h] = 1'b0;
      end
    end
  end

  always_comb begin
    cnt_nxt         = cnt_r;
    armed_nxt       = armed_r;
    elapsed_nxt     = elapsed_r;
    limit_nxt       = limit_r;
    run_pending_nxt = run_pending_r && !run_done;
    mem_we          = 1'b0;
    q_push          = 1'b0;
    q_job           = '0;
    if (accept) begin
      unique case (in_item.op)
        OP_BYTE: begin
          if (line_end) begin
            cnt_nxt = '0;
            priority if (is_ok) begin
              armed_nxt  = 1'b0;
              q_push     = 1'b1;
              q_job.kind = KIND_OK;
            end else if (is_err) begin
              armed_nxt  = 1'b0;
              q_push     = 1'b1;
              q_job.kind = KIND_ERROR;
            end else if (hit != 2'b00) begin
              q_push      = 1'b1;
              q_job.kind  = KIND_LINE;
              q_job.hook  = !hit[0];
              q_job.len   = LEN_W'(len);
              q_job.count = run_count;
              q_job.run   = (len != '0);
              if (len != '0) run_pending_nxt = 1'b1;
            end else begin
              q_push = 1'b0;
            end
          end else if (int'(cnt_r) < RX_BUF_SIZE) begin
            mem_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        OP_TICK: begin
          if (armed_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc > ELAPSED_W'(limit_r)) begin
              armed_nxt = 1'b0;
              q_push    = 1'b1;
              if (is_prompt) begin
                cnt_nxt    = '0;
                q_job.kind = KIND_PROMPT;
              end else begin
                q_job.kind = KIND_TIMEOUT;
              end
            end
          end
        end
        OP_ARM: begin
          armed_nxt   = 1'b1;
          elapsed_nxt = '0;
          limit_nxt   = in_item.wait_limit;
        end
        default: ;
      endcase
    end
  end

  // Line store and its head copy
  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[cnt_r[ADDR_W-1:0]] <= in_item.rx_byte;
      last_r <= in_item.rx_byte;
    end
    for (int i = 0; i < HEAD_BYTES; i++) begin
      if (mem_we && (cnt_r == CNT_W'(i))) head_r[i] <= in_item.rx_byte;
    end
    if (rd_req.en) begin
      rd_data_r <= line_mem[rd_req.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r           <= '0;
      armed_r         <= 1'b0;
      elapsed_r       <= '0;
      limit_r         <= '0;
      run_pending_r   <= 1'b0;
      hook_count_r    <= '0;
      first_prefix_r  <= '0;
      first_plen_r    <= '0;
      second_prefix_r <= '0;
      second_plen_r   <= '0;
    end else begin
      cnt_r         <= cnt_nxt;
      armed_r       <= armed_nxt;
      elapsed_r     <= elapsed_nxt;
      limit_r       <= limit_nxt;
      run_pending_r <= run_pending_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_HOOK_COUNT:  hook_count_r    <= cfg_data[HCOUNT_W-1:0];
          CFG_FIRST_PFX:   first_prefix_r  <= cfg_data[PREFIX_W-1:0];
          CFG_FIRST_PLEN:  first_plen_r    <= cfg_data[PLEN_W-1:0];
          CFG_SECOND_PFX:  second_prefix_r <= cfg_data[PREFIX_W-1:0];
          CFG_SECOND_PLEN: second_plen_r   <= cfg_data[PLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign rd_data     = rd_data_r;
  assign run_pending = run_pending_r;

endmodule

// ----- hw/rtl/aclp_back.sv -----
// Back: turns jobs into result words, walking the line store for captured lines.
`timescale 1ns / 1ps
module aclp_back import aclp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  jobq_stat_t q_stat,
  input  job_t       q_job,
  output logic       q_pop,
  output rd_req_t    rd_req,
  input  logic [7:0] rd_data,
  output logic       run_done,
  output logic       empty,
  input  logic       pop,
  output out_item_t  out_item
);

  bk_state_t        state_r, state_nxt;
  job_t             job_r;
  logic [RUN_W-1:0] idx_r;
  logic             out_valid_r;
  out_item_t        out_r, out_nxt;
  logic             out_free, out_load, run_last;

  assign out_free = !out_valid_r || pop;
  assign run_last = ((idx_r + RUN_W'(1)) == job_r.count);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty && q_job.run) state_nxt = BK_READ;
      BK_READ: state_nxt = BK_EMIT;
      BK_EMIT: if (out_free && run_last) state_nxt = BK_IDLE;
                else if (out_free) state_nxt = BK_READ;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = 1'b0;
    rd_req   = '0;
    out_load = 1'b0;
    out_nxt  = out_r;
    run_done = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        // a single result needs the output slot, a run only starts
        if (!q_stat.empty && (q_job.run || out_free)) begin
          q_pop = 1'b1;
          if (!q_job.run) begin
            out_load            = 1'b1;
            out_nxt.kind        = q_job.kind;
            out_nxt.hook_index  = q_job.hook;
            out_nxt.line_byte   = '0;
            out_nxt.line_length = q_job.len;
            out_nxt.last        = 1'b1;
          end
        end
      end
      BK_READ: begin
        rd_req.en   = 1'b1;
        rd_req.addr = ADDR_W'(idx_r);
      end
      BK_EMIT: begin
        if (out_free) begin
          out_load            = 1'b1;
          out_nxt.kind        = KIND_LINE;
          out_nxt.hook_index  = job_r.hook;
          out_nxt.line_byte   = rd_data;
          out_nxt.line_length = job_r.len;
          out_nxt.last        = run_last;
          run_done            = run_last;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
    if (state_r == BK_IDLE) begin
      job_r <= q_job;
      idx_r <= '0;
    end else if ((state_r == BK_EMIT) && out_free) begin
      idx_r <= idx_r + RUN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)  out_valid_r <= 1'b1;
      else if (pop)  out_valid_r <= 1'b0;
    end
  end

  assign empty    = !out_valid_r;
  assign out_item = out_r;

endmodule
